// ===== hw/rtl/cmest_pkg.sv =====
// Shared constants, types and the reciprocal table for the strip common-mode estimator.
package cmest_pkg;

    // Sensor geometry
    localparam int STRIPS_PER_GROUP  = 16;
    localparam int GROUPS_PER_SENSOR = 2;

    // Derived widths
    localparam int SLOT_W  = (STRIPS_PER_GROUP > 1) ? $clog2(STRIPS_PER_GROUP) : 1;
    localparam int GRP_W   = (GROUPS_PER_SENSOR > 1) ? $clog2(GROUPS_PER_SENSOR) : 1;
    localparam int ADDR_W  = SLOT_W + 1;
    localparam int SMP_W   = 13;
    localparam int THR_W   = SMP_W + 1;
    localparam int OFS_W   = 8;
    localparam int SUM_W   = SMP_W + SLOT_W;
    localparam int CNT_W   = $clog2(STRIPS_PER_GROUP + 1);
    localparam int RCP_W   = 12;
    localparam int PROD_W  = SUM_W + RCP_W + 1;
    localparam int CM_W    = 14;
    localparam int RND_SH  = 11;

    // Reset values
    localparam logic signed [SMP_W-1:0] MIN_RESET    = 13'sd4095;
    localparam logic [OFS_W-1:0]        OFFSET_RESET = 8'd24;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(STRIPS_PER_GROUP - 1);
    localparam logic [GRP_W-1:0]  LAST_GROUP = GRP_W'(GROUPS_PER_SENSOR - 1);
    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1024);

    // One finished group waiting for its averaging pass
    typedef struct packed {
        logic                    bank;
        logic signed [THR_W-1:0] thr;
        logic                    group;
    } t_job;

    // Back part hands a sample bank back to the front part
    typedef struct packed {
        logic vld;
        logic bank;
    } t_release;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_DRAIN,
        BK_MUL,
        BK_DONE
    } t_back_state;

    // round(2048/n) for n = index + 1
    function automatic logic [RCP_W-1:0] recip(input logic [3:0] idx);
        logic [RCP_W-1:0] r;
        unique case (idx)
            4'd0:  r = 12'd2048;
            4'd1:  r = 12'd1024;
            4'd2:  r = 12'd683;
            4'd3:  r = 12'd512;
            4'd4:  r = 12'd410;
            4'd5:  r = 12'd341;
            4'd6:  r = 12'd293;
            4'd7:  r = 12'd256;
            4'd8:  r = 12'd228;
            4'd9:  r = 12'd205;
            4'd10: r = 12'd186;
            4'd11: r = 12'd171;
            4'd12: r = 12'd158;
            4'd13: r = 12'd146;
            4'd14: r = 12'd137;
            4'd15: r = 12'd128;
            default: r = 12'd128;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/cmest_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cmest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/cmest_front.sv =====
// Front part: takes strip items, tracks position and group minimum, stores samples.
module cmest_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cmest_pkg::OFS_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [cmest_pkg::SMP_W-1:0] i_strip,
    input  logic                           i_start,
    output logic                           o_we,
    output logic [cmest_pkg::ADDR_W-1:0]   o_waddr,
    output logic [cmest_pkg::SMP_W-1:0]    o_wdata,
    output logic                           o_push,
    output cmest_pkg::t_job                o_job,
    input  logic                           i_q_full,
    input  cmest_pkg::t_release            i_release
);
    import cmest_pkg::*;

    logic [OFS_W-1:0]        r_offset;
    logic [SLOT_W-1:0]       r_slot;
    logic [GRP_W-1:0]        r_grp;
    logic signed [SMP_W-1:0] r_min;
    logic                    r_bank;
    logic [1:0]              r_busy;

    logic                    acc;
    logic [SLOT_W-1:0]       eff_slot;
    logic [GRP_W-1:0]        eff_grp;
    logic signed [SMP_W-1:0] eff_min;
    logic signed [SMP_W-1:0] new_min;
    logic                    last;

    // Take an item only when the current bank is free and a job slot is open
    assign o_ready = !r_busy[r_bank] && !i_q_full;
    assign acc     = i_valid && o_ready;

    // Sensor start restarts the position before the sample is placed
    always_comb begin
        eff_slot = i_start ? '0 : r_slot;
        eff_grp  = i_start ? '0 : r_grp;
        eff_min  = i_start ? MIN_RESET : r_min;
        new_min  = (i_strip < eff_min) ? i_strip : eff_min;
        last     = (eff_slot == LAST_SLOT);
    end

    assign o_we    = acc;
    assign o_waddr = {r_bank, eff_slot};
    assign o_wdata = i_strip;
    assign o_push  = acc && last;

    always_comb begin
        o_job.bank  = r_bank;
        o_job.thr   = THR_W'(new_min) + THR_W'($signed({1'b0, r_offset}));
        o_job.group = eff_grp[0];
    end

    // Position, minimum and bank bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_slot   <= '0;
            r_grp    <= '0;
            r_min    <= MIN_RESET;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_offset <= i_cfg_data;
            end
            if (i_release.vld) begin
                r_busy[i_release.bank] <= 1'b0;
            end
            if (acc) begin
                if (last) begin
                    r_slot         <= '0;
                    r_grp          <= (eff_grp == LAST_GROUP) ? '0 : eff_grp + 1'b1;
                    r_min          <= MIN_RESET;
                    r_bank         <= ~r_bank;
                    r_busy[r_bank] <= 1'b1;
                end else begin
                    r_slot <= eff_slot + 1'b1;
                    r_grp  <= eff_grp;
                    r_min  <= new_min;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/cmest_queue.sv =====
// Two-entry job queue between the front and back parts.
module cmest_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmest_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cmest_pkg::t_job o_job
);
    import cmest_pkg::*;

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_ent[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== hw/rtl/cmest_back.sv =====
// Back part: sweeps a stored group, sums samples at or below threshold, scales and rounds.
module cmest_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  cmest_pkg::t_job               i_job,
    output logic                          o_pop,
    output logic [cmest_pkg::ADDR_W-1:0]  o_raddr,
    input  logic [cmest_pkg::SMP_W-1:0]   i_rdata,
    output cmest_pkg::t_release           o_release,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [cmest_pkg::CM_W-1:0] o_cm,
    output logic                          o_group
);
    import cmest_pkg::*;

    t_back_state              r_state;
    t_back_state              n_state;
    t_job                     r_job;
    logic [SLOT_W-1:0]        r_idx;
    logic                     r_rd_vld;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_vld;
    logic signed [CM_W-1:0]   r_cm;
    logic                     r_group;

    logic                     load_out;
    logic                     mul_en;
    logic                     qual;
    logic [CNT_W-1:0]         cnt_m1;
    logic signed [PROD_W-1:0] biased;

    assign o_raddr = {r_job.bank, r_idx};
    assign qual    = r_rd_vld && ($signed({i_rdata[SMP_W-1], i_rdata}) <= r_job.thr);
    assign cnt_m1  = r_cnt - 1'b1;
    assign biased  = r_prod + RND_BIAS;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_q_valid) n_state = BK_SWEEP;
            BK_SWEEP: if (r_idx == LAST_SLOT) n_state = BK_DRAIN;
            BK_DRAIN: n_state = BK_MUL;
            BK_MUL:   n_state = BK_DONE;
            BK_DONE:  if (!r_out_vld || i_ready) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop          = (r_state == BK_IDLE) && i_q_valid;
        mul_en         = (r_state == BK_MUL);
        o_release.vld  = mul_en;
        o_release.bank = r_job.bank;
        load_out       = (r_state == BK_DONE) && (!r_out_vld || i_ready);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == BK_SWEEP);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Sweep, accumulate, multiply and round
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            if (r_state == BK_SWEEP) begin
                r_idx <= r_idx + 1'b1;
            end
            if (qual) begin
                r_sum <= r_sum + SUM_W'($signed(i_rdata));
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (mul_en) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'($signed({1'b0, recip(4'(cnt_m1))}));
        end
        if (load_out) begin
            r_cm    <= biased[RND_SH+CM_W-1:RND_SH];
            r_group <= r_job.group;
        end
    end

    assign o_valid = r_out_vld;
    assign o_cm    = r_cm;
    assign o_group = r_group;
endmodule

// ===== hw/rtl/strip_common_mode_estimator.sv =====
// Top level of the strip common-mode estimator.
// Strip samples enter one per cycle as long as a sample bank is free and the
// job queue has room; each group of STRIPS_PER_GROUP strips is written into
// one of two banks of a sample RAM, and its last strip queues an averaging
// job. The averaging unit reads the bank one sample per cycle, and short
// bursts run at one item per cycle while the other bank is being averaged.
// One result per group follows on the master side; a result left waiting
// there holds off new items only once the output register, the averaging
// unit, the job queue and both banks are all taken.
// The threshold offset register resets to 24 and is written through the cfg
// channel.
module strip_common_mode_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: threshold_offset
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [12:0] strip_value, [15:13] zero
    input  logic        i_s_tuser,   // [0] sensor_start
    // Result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [13:0] common_mode, [15:14] zero
    output logic        o_m_tuser    // [0] group_index
);
    import cmest_pkg::*;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SMP_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic [SMP_W-1:0]  rdata;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    t_job              push_job;
    t_job              head_job;
    t_release          release_b;
    logic signed [CM_W-1:0] cm;

    assign o_cfg_ready = 1'b1;

    cmest_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_strip     ($signed(i_s_tdata[SMP_W-1:0])),
        .i_start     (i_s_tuser),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_push      (push),
        .o_job       (push_job),
        .i_q_full    (q_full),
        .i_release   (release_b)
    );

    cmest_ram #(
        .WIDTH (SMP_W),
        .DEPTH (2 * STRIPS_PER_GROUP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cmest_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    cmest_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_release (release_b),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_cm      (cm),
        .o_group   (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, cm};
endmodule

// ===== tb/strip_common_mode_estimator_tb.sv =====
// Self-checking testbench for the strip common-mode estimator: random streams, stalls, offsets.
module strip_common_mode_estimator_tb;
    import cmest_pkg::*;

    localparam int STRIPS_PER_SENSOR = STRIPS_PER_GROUP * GROUPS_PER_SENSOR;
    localparam int PHASES            = 8;
    localparam int PHASE_STRIPS      = 112;
    localparam int SETTLE_CYCLES     = 2 * (STRIPS_PER_GROUP + 4) + 10;
    localparam int MAX_REPORTS       = 10;

    typedef struct {
        logic signed [SMP_W-1:0] value;
        logic                    start;
    } t_strip;

    typedef struct {
        logic [CM_W-1:0] cm;
        logic            grp;
    } t_cm_result;

    // How strip values of a group are drawn
    typedef enum int {
        VAL_ANY,
        VAL_PEDESTAL,
        VAL_EXTREME,
        VAL_FLAT
    } t_value_style;

    // Shapes of strip sequences
    typedef enum int {
        SEQ_SENSOR,
        SEQ_NO_START,
        SEQ_CUT,
        SEQ_NOISE
    } t_seq_kind;

    // Clock, reset and block inputs, all known from time zero
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [OFS_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic [15:0]         s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tready  = 1'b0;
    logic                o_cfg_ready;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [15:0]         o_m_tdata;
    logic                o_m_tuser;

    // Expected-value model state
    logic signed [SMP_W-1:0] model_samples [STRIPS_PER_GROUP];
    int                      model_position;
    logic signed [SMP_W-1:0] model_minimum;
    logic [OFS_W-1:0]        model_offset;
    int                      recip_by_count [16] = '{2048, 1024, 683, 512, 410, 341, 293, 256,
                                                     228, 205, 186, 171, 158, 146, 137, 128};

    t_strip     strip_backlog [$];
    t_cm_result pending_common_modes [$];
    t_strip     s_driven;

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int send_gap          = 0;
    int take_gap          = 0;
    bit hold_for_results  = 1'b0;
    int strips_queued     = 0;
    int strips_accepted   = 0;
    int results_checked   = 0;
    int starts_sent       = 0;
    int offsets_written   = 0;
    int result_pauses     = 0;
    int mismatches        = 0;

    strip_common_mode_estimator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Wait before the next item: none, or a random nonzero wait with the given percent chance
    function automatic int draw_wait(input int pct);
        if (int'($urandom_range(0, 99)) < pct)
            return int'($urandom_range(1, 16));
        return 0;
    endfunction

    // Track one accepted strip; a group's last strip yields its common mode
    function automatic void absorb_strip(input t_strip it);
        int         slot;
        int         grp;
        int         thr;
        int         count;
        longint     sum;
        longint     avg;
        t_cm_result r;
        if (it.start) begin
            model_position = 0;
            model_minimum  = MIN_RESET;
        end
        if (model_position >= STRIPS_PER_SENSOR)
            model_position = 0;
        slot = model_position % STRIPS_PER_GROUP;
        grp  = model_position / STRIPS_PER_GROUP;
        model_samples[slot] = it.value;
        if (it.value < model_minimum)
            model_minimum = it.value;
        if (slot == STRIPS_PER_GROUP - 1) begin
            thr   = int'(model_minimum) + int'(model_offset);
            sum   = 0;
            count = 0;
            for (int i = 0; i < STRIPS_PER_GROUP; i++) begin
                if (int'(model_samples[i]) <= thr) begin
                    sum += longint'(model_samples[i]);
                    count++;
                end
            end
            if (count == 0)
                count = 1;
            // round half up: floor((sum * 2048/n + 1024) / 2048)
            avg  = (sum * longint'(recip_by_count[count - 1]) + 1024) >>> 11;
            r.cm  = avg[CM_W-1:0];
            r.grp = grp[0];
            pending_common_modes = {pending_common_modes, r};
            model_minimum = MIN_RESET;
        end
        model_position = (model_position + 1) % STRIPS_PER_SENSOR;
    endfunction

    function automatic void note_mismatch(input string what, input t_cm_result want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s: expected cm=%0d grp=%0d, got cm=%0d grp=%0d",
                     $time, what, $signed(want.cm), want.grp,
                     $signed(o_m_tdata[CM_W-1:0]), o_m_tuser);
    endfunction

    // Input driver: one item per handshake, random gaps, occasional drain pause
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                absorb_strip(s_driven);
                strips_accepted++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (hold_for_results && pending_common_modes.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (strip_backlog.size() != 0) begin
                    if (hold_for_results)
                        result_pauses++;
                    s_driven = strip_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, s_driven.value};
                    s_tuser  <= s_driven.start;
                    hold_for_results = (int'($urandom_range(0, 99)) < 3);
                    send_gap = draw_wait(send_idle_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result with the oldest expectation
    always @(posedge clk) begin
        t_cm_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            take_gap = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (pending_common_modes.size() == 0) begin
                    want.cm  = '0;
                    want.grp = 1'b0;
                    note_mismatch("unexpected result", want);
                end else begin
                    want = pending_common_modes.pop_front();
                    if (o_m_tdata[CM_W-1:0] !== want.cm || o_m_tuser !== want.grp)
                        note_mismatch("wrong result", want);
                    results_checked++;
                end
                take_gap = draw_wait(recv_idle_pct);
            end
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_strip(input int value, input logic start);
        t_strip it;
        it.value = value[SMP_W-1:0];
        it.start = start;
        strip_backlog = {strip_backlog, it};
        strips_queued++;
        if (start)
            starts_sent++;
    endtask

    function automatic int draw_value(input t_value_style style, input int base);
        int v;
        case (style)
            VAL_ANY: begin
                v = int'($urandom_range(0, 8191)) - 4096;
            end
            VAL_PEDESTAL: begin
                v = base + int'($urandom_range(0, 40)) - 20;
                // a few strips carry a hit well above the noise
                if ($urandom_range(0, 4) == 0)
                    v += int'($urandom_range(0, 3000));
            end
            VAL_EXTREME: begin
                v = $urandom_range(0, 1) ? 4095 : -4096;
            end
            default: begin
                v = base + int'($urandom_range(0, 3));
            end
        endcase
        if (v > 4095)
            v = 4095;
        if (v < -4096)
            v = -4096;
        return v;
    endfunction

    // Queue a run of strips, with a fresh pedestal for each group
    task automatic queue_run(input int count, input bit first_start, input t_value_style style);
        int base;
        base = int'($urandom_range(0, 8191)) - 4096;
        for (int i = 0; i < count; i++) begin
            if (i % STRIPS_PER_GROUP == 0)
                base = int'($urandom_range(0, 8191)) - 4096;
            queue_strip(draw_value(style, base), first_start && i == 0);
        end
    endtask

    // Mostly whole sensors, with unmarked sensors, cut sensors and noise mixed in
    task automatic queue_phase(input int target);
        int           start_count;
        t_seq_kind    kind;
        t_value_style style;
        start_count = strips_queued;
        while (strips_queued - start_count < target) begin
            style = t_value_style'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: kind = SEQ_SENSOR;
                7:                   kind = SEQ_NO_START;
                8:                   kind = SEQ_CUT;
                default:             kind = SEQ_NOISE;
            endcase
            case (kind)
                SEQ_SENSOR:   queue_run(STRIPS_PER_SENSOR, 1'b1, style);
                SEQ_NO_START: queue_run(STRIPS_PER_SENSOR, 1'b0, style);
                SEQ_CUT:      queue_run($urandom_range(1, STRIPS_PER_SENSOR - 1), 1'b1, style);
                default: begin
                    repeat ($urandom_range(1, 20))
                        queue_strip(draw_value(VAL_ANY, 0), $urandom_range(0, 3) == 0);
                end
            endcase
        end
    endtask

    // Wait until every queued strip is taken and every result has come
    task automatic wait_for_drain();
        while (strips_accepted != strips_queued || pending_common_modes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_offset = value;
        offsets_written++;
    endtask

    // Stimulus: directed sensor first, then random phases at several offsets
    initial begin
        model_position = 0;
        model_minimum  = MIN_RESET;
        model_offset   = OFFSET_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // group 0: a single strip at the negative extreme qualifies
        for (int i = 0; i < STRIPS_PER_GROUP; i++)
            queue_strip((i == 7) ? -4096 : 4095, i == 0);
        // group 1 cut short by a new sensor start, so it is dropped
        for (int i = 0; i < 5; i++)
            queue_strip(-1000 - i, 1'b0);
        // whole group at the positive extreme: every strip qualifies
        for (int i = 0; i < STRIPS_PER_GROUP; i++)
            queue_strip(4095, i == 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(0, 80);
                recv_idle_pct = $urandom_range(0, 80);
            end
            if (phase > 0) begin
                // block must be idle: all results in, averaging pass settled
                wait_for_drain();
                repeat (SETTLE_CYCLES) @(posedge clk);
                case (phase)
                    1:       write_offset('0);
                    2:       write_offset('1);
                    PHASES - 1: write_offset(OFFSET_RESET);
                    default: write_offset(OFS_W'($urandom_range(0, 255)));
                endcase
            end
            queue_phase(PHASE_STRIPS);
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_common_modes.size() != 0) begin
            mismatches += pending_common_modes.size();
            $display("%0d expected results never arrived", pending_common_modes.size());
        end
        $display("Sent %0d strips (%0d sensor starts), checked %0d common-mode results",
                 strips_accepted, starts_sent, results_checked);
        $display("Offsets written: %0d, drain pauses: %0d, mismatches: %0d",
                 offsets_written, result_pauses, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("timeout: estimator stopped making progress");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
